>>> hdl/hsl2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Shared constants for the HSL to RGB565 converter: field widths, hue sector
// geometry and the default fixed-point precision.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

	// default fraction bits of the Q1.F saturation / lightness format
	localparam int FRAC_BITS_DEF = 10;

	// input field widths
	localparam int HUE_W  = 9;
	localparam int UNIT_W = 11;

	// output channel widths
	localparam int RED_W   = 5;
	localparam int GREEN_W = 6;
	localparam int BLUE_W  = 5;
	localparam int PIX_W   = RED_W + GREEN_W + BLUE_W;

	// hue sectors of 60 degrees; a 9-bit hue reaches sector 8
	localparam int DEG_PER_SECT = 60;
	localparam int SECT_CNT     = ((1 << HUE_W) - 1) / DEG_PER_SECT + 1;
	localparam int SECT_W       = $clog2(SECT_CNT);
	localparam int REM_W        = $clog2(DEG_PER_SECT);

endpackage

>>> hdl/hsl2rgb_hue.sv
// ----------------------------------------------------------------------------
// hsl2rgb_hue
// Two-stage hue front end: splits the hue into its 60-degree sector and the
// remainder, then looks up the fractional position and forms the weight
// (1 - |hp mod 2 - 1|) used for the secondary component X.
// ----------------------------------------------------------------------------
module hsl2rgb_hue
	import hsl2rgb_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic [HUE_W-1:0]     hue,
	output logic [SECT_W-1:0]    sector_s2,
	output logic [FRAC_BITS:0]   weight_s2
);

	localparam int UW = FRAC_BITS + 1;
	localparam logic [UW-1:0] ONE_U = UW'(1) << FRAC_BITS;
	localparam int TBL_N = 1 << REM_W;

	logic [SECT_W-1:0]    sect_c;
	logic [REM_W-1:0]     rem_c;
	logic [SECT_W-1:0]    sector_s1;
	logic [REM_W-1:0]     rem_s1;
	logic [FRAC_BITS-1:0] frac_tbl [TBL_N];
	logic [FRAC_BITS-1:0] frac_c;

	// fraction table: floor(r * ONE / 60) for each remainder
	for (genvar gi = 0; gi < TBL_N; gi++) begin : g_tbl
		localparam int FRAC_V = (gi << FRAC_BITS) / DEG_PER_SECT;
		assign frac_tbl[gi] = FRAC_BITS'(FRAC_V);
	end

	// sector by threshold compare, remainder by constant multiple
	always_comb begin
		sect_c = '0;
		for (int k = 1; k < SECT_CNT; k++) begin
			if (hue >= HUE_W'(k * DEG_PER_SECT))
				sect_c = SECT_W'(k);
		end
		rem_c = REM_W'(hue - HUE_W'(sect_c * HUE_W'(DEG_PER_SECT)));
	end

	// stage 1
	always_ff @(posedge clk) begin
		sector_s1 <= sect_c;
		rem_s1    <= rem_c;
	end

	// even sector: weight = frac, odd sector: weight = ONE - frac
	assign frac_c = frac_tbl[rem_s1];

	// stage 2
	always_ff @(posedge clk) begin
		sector_s2 <= sector_s1;
		weight_s2 <= sector_s1[0] ? (ONE_U - UW'(frac_c)) : UW'(frac_c);
	end

endmodule

>>> hdl/hsl_to_rgb565.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb565
// Five-stage pipelined HSL to RGB565 pixel converter.
//
//   channel  direction  ports                              handshake
//   input    in         hue, saturation, lightness         start / busy
//   result   out        red, green, blue, packed_color     done strobe
//
// One word enters per clock; busy stays low since nothing ever stalls.
// Each word passes from start to done through the registered stage split:
// hue sector, chroma span, chroma multiply, X multiply, channel mapping.
// Reset clears only the valid bits; payload registers are not reset.
// The receiver cannot hold off a result, so each word is shown for one cycle.
// ----------------------------------------------------------------------------
module hsl_to_rgb565
	import hsl2rgb_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [HUE_W-1:0]    hue,
	input  logic [UNIT_W-1:0]   saturation,
	input  logic [UNIT_W-1:0]   lightness,
	output logic                done,
	output logic [RED_W-1:0]    red,
	output logic [GREEN_W-1:0]  green,
	output logic [BLUE_W-1:0]   blue,
	output logic [PIX_W-1:0]    packed_color
);

	localparam int UW = FRAC_BITS + 1;
	localparam int CW = (UW > UNIT_W) ? UW : UNIT_W;
	localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;
	localparam logic [UW-1:0] ONE_U = UW'(1) << FRAC_BITS;
	localparam logic [UW:0]   ONE_X = (UW + 1)'(1) << FRAC_BITS;
	localparam int RB_SH = FRAC_BITS - RED_W;
	localparam int G_SH  = FRAC_BITS - GREEN_W;
	localparam logic [UW:0] RB_MAX = (UW + 1)'((1 << RED_W) - 1);
	localparam logic [UW:0] G_MAX  = (UW + 1)'((1 << GREEN_W) - 1);

	logic in_acc;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [UW-1:0] sat_c, lit_c;
	logic [UW-1:0] sat_s1, lit_s1;
	logic [UW-1:0] sat_s2, lit_s2, span_s2;
	logic [UW:0]   twol_c, dist_c;

	logic [SECT_W-1:0] sector_s2, sector_s3, sector_s4;
	logic [UW-1:0]     weight_s2, weight_s3;

	logic [2*UW-1:0] cprod_c;
	logic [UW-1:0]   chroma_s3, lit_s3;

	logic [2*UW-1:0] xprod_c;
	logic [UW-1:0]   chroma_s4, xval_s4, mval_s4;

	logic [UW-1:0] r1_c, g1_c, b1_c;
	logic [UW:0]   rv_c, gv_c, bv_c;
	logic [UW:0]   rq_c, gq_c, bq_c;
	logic [RED_W-1:0]   red_c;
	logic [GREEN_W-1:0] green_c;
	logic [BLUE_W-1:0]  blue_c;

	assign busy   = 1'b0;
	assign in_acc = start & ~busy;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			done <= v_s4;
		end
	end

	// hue sector and X weight, two stages
	hsl2rgb_hue #(
		.FRAC_BITS (FRAC_BITS)
	) u_hue (
		.clk       (clk),
		.hue       (hue),
		.sector_s2 (sector_s2),
		.weight_s2 (weight_s2)
	);

	// stage 1: clamp saturation and lightness to one
	assign sat_c = (CW'(saturation) > ONE_C) ? ONE_U : UW'(saturation);
	assign lit_c = (CW'(lightness) > ONE_C) ? ONE_U : UW'(lightness);

	always_ff @(posedge clk) begin
		sat_s1 <= sat_c;
		lit_s1 <= lit_c;
	end

	// stage 2: span = ONE - |2L - ONE|
	assign twol_c = {lit_s1, 1'b0};
	assign dist_c = (twol_c >= ONE_X) ? (twol_c - ONE_X) : (ONE_X - twol_c);

	always_ff @(posedge clk) begin
		sat_s2  <= sat_s1;
		lit_s2  <= lit_s1;
		span_s2 <= UW'(ONE_X - dist_c);
	end

	// stage 3: chroma = span * S / ONE
	assign cprod_c = span_s2 * sat_s2;

	always_ff @(posedge clk) begin
		chroma_s3 <= UW'(cprod_c >> FRAC_BITS);
		lit_s3    <= lit_s2;
		sector_s3 <= sector_s2;
		weight_s3 <= weight_s2;
	end

	// stage 4: X = chroma * weight / ONE, m = L - chroma / 2
	assign xprod_c = chroma_s3 * weight_s3;

	always_ff @(posedge clk) begin
		chroma_s4 <= chroma_s3;
		xval_s4   <= UW'(xprod_c >> FRAC_BITS);
		mval_s4   <= lit_s3 - (chroma_s3 >> 1);
		sector_s4 <= sector_s3;
	end

	// stage 5: place C and X by sector, add m, scale and saturate
	always_comb begin
		r1_c = '0;
		g1_c = '0;
		b1_c = '0;
		unique case (sector_s4)
			SECT_W'(0): begin r1_c = chroma_s4; g1_c = xval_s4;   end
			SECT_W'(1): begin r1_c = xval_s4;   g1_c = chroma_s4; end
			SECT_W'(2): begin g1_c = chroma_s4; b1_c = xval_s4;   end
			SECT_W'(3): begin g1_c = xval_s4;   b1_c = chroma_s4; end
			SECT_W'(4): begin r1_c = xval_s4;   b1_c = chroma_s4; end
			SECT_W'(5): begin r1_c = chroma_s4; b1_c = xval_s4;   end
			default: begin
				// hue past the last sector: gray level only
			end
		endcase

		rv_c = (UW + 1)'(r1_c) + (UW + 1)'(mval_s4);
		gv_c = (UW + 1)'(g1_c) + (UW + 1)'(mval_s4);
		bv_c = (UW + 1)'(b1_c) + (UW + 1)'(mval_s4);

		rq_c = rv_c >> RB_SH;
		gq_c = gv_c >> G_SH;
		bq_c = bv_c >> RB_SH;

		red_c   = (rq_c > RB_MAX) ? {RED_W{1'b1}}   : RED_W'(rq_c);
		green_c = (gq_c > G_MAX)  ? {GREEN_W{1'b1}} : GREEN_W'(gq_c);
		blue_c  = (bq_c > RB_MAX) ? {BLUE_W{1'b1}}  : BLUE_W'(bq_c);
	end

	// output word registers
	always_ff @(posedge clk) begin
		red          <= red_c;
		green        <= green_c;
		blue         <= blue_c;
		packed_color <= {red_c, green_c, blue_c};
	end

endmodule

>>> bench/hsl_to_rgb565_test.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb565_test
// Self-checking bench for the HSL to RGB565 converter. Pixels are pushed in
// through start / busy; a local fixed-point predictor computes each expected
// RGB565 word, and every done strobe is checked in order against it. Directed
// corners and out-of-range inputs come first, then random streams under
// several sender idle rates.
// ----------------------------------------------------------------------------
module hsl_to_rgb565_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hsl2rgb_pkg::*;

	localparam int          FRAC        = FRAC_BITS_DEF;
	localparam int unsigned UNIT        = 1 << FRAC;
	localparam int unsigned UNIT_MAX    = (1 << UNIT_W) - 1;
	localparam int unsigned HUE_MAX     = (1 << HUE_W) - 1;
	localparam int unsigned HUE_TOP     = 359;
	localparam int          DRAIN_WAIT  = 12;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          REPORT_MAX  = 10;

	// hue sectors of the conversion, sixty degrees each
	typedef enum int unsigned {
		SECT_R_TO_Y,
		SECT_Y_TO_G,
		SECT_G_TO_C,
		SECT_C_TO_B,
		SECT_B_TO_M,
		SECT_M_TO_R
	} hue_sector_t;

	typedef struct packed {
		logic [RED_W-1:0]   red;
		logic [GREEN_W-1:0] green;
		logic [BLUE_W-1:0]  blue;
		logic [PIX_W-1:0]   packed_color;
	} rgb565_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [HUE_W-1:0]    hue;
	logic [UNIT_W-1:0]   saturation;
	logic [UNIT_W-1:0]   lightness;
	logic                done;
	logic [RED_W-1:0]    red;
	logic [GREEN_W-1:0]  green;
	logic [BLUE_W-1:0]   blue;
	logic [PIX_W-1:0]    packed_color;

	rgb565_t expected_pixels[$];
	int      pixels_sent;
	int      pixels_checked;
	int      mismatch_count;
	int      error_count;
	int      cycle_count;

	hsl_to_rgb565 i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.hue         (hue),
		.saturation  (saturation),
		.lightness   (lightness),
		.done        (done),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.packed_color(packed_color)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// scale a component to a channel width, clipped at the channel maximum
	function automatic int unsigned scale_channel(input int unsigned v,
			input int unsigned scale, input int unsigned maxv);
		int unsigned q;
		q = (v * scale) >> FRAC;
		return (q > maxv) ? maxv : q;
	endfunction

	// fixed-point HSL to RGB565 conversion
	function automatic rgb565_t predict_rgb565(input logic [HUE_W-1:0] h,
			input logic [UNIT_W-1:0] s_in, input logic [UNIT_W-1:0] l_in);
		int unsigned s, l, twol, ldist, chroma, hp, sector, hmod, hd, xval, m;
		int unsigned r1, g1, b1, rc, gc, bc;
		rgb565_t     px;
		// saturation and lightness above one are clipped to one
		s      = (s_in > UNIT) ? UNIT : s_in;
		l      = (l_in > UNIT) ? UNIT : l_in;
		twol   = l << 1;
		ldist  = (twol >= UNIT) ? twol - UNIT : UNIT - twol;
		chroma = ((UNIT - ldist) * s) >> FRAC;
		hp     = (int'(h) << FRAC) / 60;
		sector = hp >> FRAC;
		hmod   = hp & ((UNIT << 1) - 1);
		hd     = (hmod >= UNIT) ? hmod - UNIT : UNIT - hmod;
		xval   = (chroma * (UNIT - hd)) >> FRAC;
		m      = l - (chroma >> 1);
		r1 = 0;
		g1 = 0;
		b1 = 0;
		// hue past 359 lands beyond the last sector: gray level only
		case (sector)
			SECT_R_TO_Y: begin r1 = chroma; g1 = xval; end
			SECT_Y_TO_G: begin r1 = xval; g1 = chroma; end
			SECT_G_TO_C: begin g1 = chroma; b1 = xval; end
			SECT_C_TO_B: begin g1 = xval; b1 = chroma; end
			SECT_B_TO_M: begin r1 = xval; b1 = chroma; end
			SECT_M_TO_R: begin r1 = chroma; b1 = xval; end
			default: ;
		endcase
		rc = scale_channel(r1 + m, 32, (1 << RED_W) - 1);
		gc = scale_channel(g1 + m, 64, (1 << GREEN_W) - 1);
		bc = scale_channel(b1 + m, 32, (1 << BLUE_W) - 1);
		px.red          = rc[RED_W-1:0];
		px.green        = gc[GREEN_W-1:0];
		px.blue         = bc[BLUE_W-1:0];
		px.packed_color = {px.red, px.green, px.blue};
		return px;
	endfunction

	// mostly in range, a share of exact corners and of over-range values
	function automatic logic [UNIT_W-1:0] pick_unit();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 6)
			return '0;
		if (r < 12)
			return UNIT_W'(UNIT);
		if (r < 15)
			return UNIT_W'(UNIT / 2);
		if (r < 85)
			return UNIT_W'($urandom_range(UNIT));
		return UNIT_W'($urandom_range(UNIT_MAX, UNIT + 1));
	endfunction

	function automatic logic [HUE_W-1:0] pick_hue();
		if ($urandom_range(99) < 10)
			return HUE_W'($urandom_range(HUE_MAX, HUE_TOP + 1));
		return HUE_W'($urandom_range(HUE_TOP));
	endfunction

	// offer one word and hold it until taken
	task automatic send_pixel(input logic [HUE_W-1:0] h, input logic [UNIT_W-1:0] s,
			input logic [UNIT_W-1:0] l);
		start      <= 1'b1;
		hue        <= h;
		saturation <= s;
		lightness  <= l;
		do @(posedge clk); while (busy);
		expected_pixels.push_back(predict_rgb565(h, s, l));
		pixels_sent++;
	endtask

	// one cycle with start low and junk on the fields
	task automatic idle_cycle();
		start      <= 1'b0;
		hue        <= HUE_W'($urandom);
		saturation <= UNIT_W'($urandom);
		lightness  <= UNIT_W'($urandom);
		@(posedge clk);
	endtask

	// black, white, primaries, sector boundaries and mid-sector blends
	task automatic test_field_extremes();
		send_pixel(0, 0, 0);
		send_pixel(0, UNIT, UNIT);
		send_pixel(0, 0, UNIT);
		send_pixel(0, UNIT, UNIT / 2);
		send_pixel(60, UNIT, UNIT / 2);
		send_pixel(120, UNIT, UNIT / 2);
		send_pixel(180, UNIT / 2, UNIT / 4);
		send_pixel(240, UNIT, UNIT / 2);
		send_pixel(300, UNIT, UNIT / 2);
		send_pixel(HUE_TOP, UNIT, UNIT / 2);
		send_pixel(30, UNIT, UNIT / 2);
		send_pixel(256, 1, UNIT - 1);
		send_pixel(90, UNIT, 768);
		idle_cycle();
	endtask

	// over-range saturation / lightness and hue past the last sector
	task automatic test_out_of_range();
		send_pixel(15, UNIT_MAX, UNIT / 2);
		send_pixel(200, UNIT, UNIT_MAX);
		send_pixel(100, UNIT + 1, 1536);
		send_pixel(HUE_TOP + 1, UNIT, UNIT / 2);
		send_pixel(400, UNIT, 300);
		send_pixel(HUE_MAX, UNIT_MAX, UNIT_MAX);
		send_pixel(HUE_MAX, UNIT, 0);
		send_pixel(HUE_MAX - 1, UNIT_MAX, 700);
		idle_cycle();
	endtask

	// random words with the sender idling idle_pct percent of cycles
	task automatic test_random_stream(input int count, input int idle_pct);
		for (int n = 0; n < count; n++) begin
			send_pixel(pick_hue(), pick_unit(), pick_unit());
			while ($urandom_range(99) < idle_pct)
				idle_cycle();
		end
		idle_cycle();
	endtask

	// compare each done word with the oldest expectation
	always @(posedge clk) begin
		rgb565_t want;
		if (arst_n && done) begin
			if (expected_pixels.size() == 0) begin
				error_count++;
				$display("%0t: result with nothing expected: r=%0d g=%0d b=%0d word=%h",
					$realtime, red, green, blue, packed_color);
			end else begin
				want = expected_pixels.pop_front();
				pixels_checked++;
				if (red !== want.red || green !== want.green || blue !== want.blue ||
						packed_color !== want.packed_color) begin
					mismatch_count++;
					error_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("%0t: pixel %0d mismatch: exp r=%0d g=%0d b=%0d word=%h, %s",
							$realtime, pixels_checked, want.red, want.green, want.blue,
							want.packed_color,
							$sformatf("got r=%0d g=%0d b=%0d word=%h",
								red, green, blue, packed_color));
				end
			end
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
			expected_pixels.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		pixels_sent    = 0;
		pixels_checked = 0;
		mismatch_count = 0;
		error_count    = 0;
		arst_n         = 1'b0;
		start          = 1'b0;
		hue            = '0;
		saturation     = '0;
		lightness      = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_out_of_range();
		test_random_stream(200, 0);
		test_random_stream(150, 86);
		test_random_stream(150, 7);

		// drain the pipeline, then watch for stray strobes
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d pixels (corners, over-range S/L, hue past 359, random streams)",
			pixels_sent);
		$display("Checked %0d results under back-to-back, sparse and light sender idling",
			pixels_checked);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d errors, %0d mismatching pixels", error_count, mismatch_count);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
